[design/lsmb_pkg.sv]
package lsmb_pkg;

  localparam int OUT_FRAC_BITS = 29;
  localparam int SH = 30 - OUT_FRAC_BITS;
  localparam int OPW = 33;
  localparam int PW = 2 * OPW;
  localparam int AW = PW + 2;

  typedef logic signed [OPW-1:0] op_t;
  typedef logic signed [PW-1:0]  pr_t;
  typedef logic signed [AW-1:0]  acc_t;

  localparam op_t  ONE30 = op_t'(64'sd1 <<< 30);
  localparam logic signed [31:0] ONE_OUT = 32'(64'sd1 <<< OUT_FRAC_BITS);

  // constant divides: 100 << SH and 199 << SH, rounded half added up front
  localparam logic        SEL_A = 1'b0;
  localparam logic        SEL_B = 1'b1;
  localparam logic [63:0] HALF_A = 64'((100 << SH) >> 1);
  localparam logic [63:0] HALF_B = 64'((199 << SH) >> 1);
  localparam logic [7:0]  D_A = 8'd100;
  localparam logic [7:0]  D_B = 8'd199;
  // 2^24 / divisor rounded up; exact for partial remainders below 2^16
  localparam logic [17:0] REC_A = 18'd167773;
  localparam logic [17:0] REC_B = 18'd84308;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [1:0]         column_index;
    logic signed [31:0] row0;
    logic signed [31:0] row1;
    logic signed [31:0] row2;
    logic signed [31:0] row3;
    logic               last_column;
  } col_t;

  // queued direction plus its zero-length flag
  typedef struct packed {
    dir_t d;
    logic zero;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  typedef struct packed {
    logic push;
    col_t col;
  } bq_t;

  // round to nearest, ties away from zero, divide by 2^k
  function automatic acc_t rnd_shift(input acc_t x, input int k);
    acc_t half;
    acc_t m;
    half = acc_t'(1) <<< (k - 1);
    if (x < 0) begin
      m = (-x + half) >>> k;
      return -m;
    end
    return (x + half) >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input acc_t v);
    if (v > acc_t'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < acc_t'(-64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic op_t clamp_unit(input logic signed [63:0] q);
    if (q > 64'(ONE30)) return ONE30;
    if (q < -64'(ONE30)) return -ONE30;
    return q[OPW-1:0];
  endfunction

endpackage

[design/lsmb_front.sv]
module lsmb_front import lsmb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  dir_t dir,
  output fq_t  head,
  input  logic deq
);

  item_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = cnt == 2'd2;
  assign do_push = push && !full;
  assign do_pop  = deq && cnt != 2'd0;
  assign head.valid = cnt != 2'd0;
  assign head.item  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        q[wp].d    <= dir;
        q[wp].zero <= dir.dir_x == 16'sd0 && dir.dir_y == 16'sd0 && dir.dir_z == 16'sd0;
        wp <= ~wp;
      end
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[design/lsmb_div.sv]
module lsmb_div import lsmb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [31:0]        den,
  output logic               done,
  output logic signed [63:0] quo
);

  logic [63:0] dvd;
  logic [31:0] rem;
  logic [31:0] den_r;
  logic [6:0]  cnt;
  logic        neg;
  logic        busy;
  logic [63:0] mag;
  logic [32:0] remx;
  logic        qbit;

  assign mag  = (num < 0 ? 64'(-num) : 64'(num)) + 64'(den >> 1);
  assign remx = {rem, dvd[63]};
  assign qbit = remx >= {1'b0, den_r};
  assign quo  = den_r == 32'd0 ? 64'sd0 : (neg ? -$signed(dvd) : $signed(dvd));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd   <= mag;
        rem   <= 32'd0;
        den_r <= den;
        neg   <= num < 0;
        cnt   <= 7'd64;
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= qbit ? 32'(remx - {1'b0, den_r}) : remx[31:0];
        dvd <= {dvd[62:0], qbit};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// rounded divide by (100 or 199) << SH: one quotient byte per cycle by reciprocal
module lsmb_cdiv import lsmb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic               sel,
  output logic               done,
  output logic signed [63:0] quo
);

  logic [63:0] src;
  logic [63:0] q;
  logic [7:0]  rem;
  logic [3:0]  cnt;
  logic        neg;
  logic        sel_r;
  logic        busy;
  logic [63:0] mag;
  logic [15:0] x;
  logic [33:0] prod;
  logic [7:0]  qd;
  logic [15:0] rnext;

  assign mag   = ((num < 0 ? 64'(-num) : 64'(num)) + (sel == SEL_B ? HALF_B : HALF_A)) >> SH;
  assign x     = {rem, src[63:56]};
  assign prod  = 34'(x) * 34'(sel_r == SEL_B ? REC_B : REC_A);
  assign qd    = prod[31:24];
  assign rnext = x - 16'(qd) * 16'(sel_r == SEL_B ? D_B : D_A);
  assign quo   = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        src   <= mag;
        q     <= '0;
        rem   <= '0;
        neg   <= num < 0;
        sel_r <= sel;
        cnt   <= 4'd8;
        busy  <= 1'b1;
      end else if (busy) begin
        q   <= {q[55:0], qd};
        rem <= rnext[7:0];
        src <= {src[55:0], 8'd0};
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/lsmb_sqrt.sv]
module lsmb_sqrt import lsmb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] src;
  logic [35:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] remx;
  logic [35:0] trial;

  assign remx  = {rem[33:0], src[63:62]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        src  <= x;
        rem  <= 36'd0;
        root <= 32'd0;
        cnt  <= 6'd32;
        busy <= 1'b1;
      end else if (busy) begin
        if (remx >= trial) begin
          rem  <= remx - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= remx;
          root <= {root[30:0], 1'b0};
        end
        src <= {src[61:0], 2'b00};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/lsmb_back.sv]
module lsmb_back import lsmb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  fq_t  head,
  output logic deq,
  input  logic out_full,
  output bq_t  bq
);

  typedef enum logic [3:0] {
    P_IDLE, P_SS, P_SQ1, P_F, P_PAR, P_RR, P_SQ2, P_R,
    P_U, P_RF, P_UF, P_FF, P_COL, P_NUM, P_EMIT
  } step_t;

  step_t step;
  logic [1:0] idx;
  logic [1:0] jdx;
  logic [1:0] mac_t;
  logic       prod_v;
  pr_t        prod;
  acc_t       acc;
  acc_t       rf;
  acc_t       uf;
  acc_t       ffx;
  logic signed [15:0] dv [3];
  op_t        f [3];
  op_t        r [3];
  op_t        u [3];
  logic signed [31:0] rows [4];

  logic               div_start;
  logic signed [63:0] div_num;
  logic [31:0]        div_den;
  logic               div_done;
  logic signed [63:0] div_q;
  logic               cd_start;
  logic               cd_sel;
  logic               cd_done;
  logic signed [63:0] cd_q;
  logic               sq_start;
  logic [63:0]        sq_in;
  logic               sq_done;
  logic [31:0]        sq_root;

  op_t        ma;
  op_t        mb;
  logic       mneg;
  pr_t        mprod;
  logic       mac_step;
  logic [1:0] nterms;
  logic       mac_done;
  logic [1:0] ti;
  logic [1:0] uj;
  logic [1:0] uk;
  op_t        absf2;
  logic       par;
  logic [1:0] nidx;

  lsmb_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  lsmb_cdiv u_cdiv (
    .clk(clk), .rst(rst), .start(cd_start), .num(div_num), .sel(cd_sel),
    .done(cd_done), .quo(cd_q)
  );

  lsmb_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(sq_in), .done(sq_done), .root(sq_root)
  );

  assign deq = step == P_IDLE && head.valid;
  assign bq.push = step == P_EMIT && !out_full;
  assign bq.col.column_index = idx;
  assign bq.col.row0 = rows[0];
  assign bq.col.row1 = rows[1];
  assign bq.col.row2 = rows[2];
  assign bq.col.row3 = rows[3];
  assign bq.col.last_column = idx == 2'd3;

  assign mac_step = step == P_SS || step == P_RR || step == P_U ||
                    step == P_RF || step == P_UF || step == P_FF;
  assign nterms   = step == P_U ? 2'd2 : 2'd3;
  assign mac_done = mac_step && mac_t == nterms && !prod_v;
  assign ti       = mac_t == 2'd3 ? 2'd0 : mac_t;
  assign mprod    = ma * mb;
  assign absf2    = f[2] < 0 ? -f[2] : f[2];
  assign par      = 41'(absf2) * 41'd100 > 41'd99 * 41'(ONE30);
  assign nidx     = idx + 2'd1;

  always_comb begin
    case (idx)
      2'd0:    begin uj = 2'd1; uk = 2'd2; end
      2'd1:    begin uj = 2'd2; uk = 2'd0; end
      default: begin uj = 2'd0; uk = 2'd1; end
    endcase
  end

  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    case (step)
      P_SS: begin ma = op_t'(dv[ti]); mb = op_t'(dv[ti]); end
      P_RR: begin ma = r[ti]; mb = r[ti]; end
      P_RF: begin ma = r[ti]; mb = f[ti]; end
      P_UF: begin ma = u[ti]; mb = f[ti]; end
      P_FF: begin ma = f[ti]; mb = f[ti]; end
      P_U: begin
        if (mac_t == 2'd0) begin
          ma = r[uj]; mb = f[uk];
        end else begin
          ma = r[uk]; mb = f[uj]; mneg = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= P_IDLE;
      idx       <= 2'd0;
      jdx       <= 2'd0;
      mac_t     <= 2'd0;
      prod_v    <= 1'b0;
      div_start <= 1'b0;
      cd_start  <= 1'b0;
      sq_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      cd_start  <= 1'b0;
      sq_start  <= 1'b0;

      if (mac_step) begin
        if (mac_t != nterms) begin
          prod   <= mneg ? -mprod : mprod;
          prod_v <= 1'b1;
          mac_t  <= mac_t + 2'd1;
        end else begin
          prod_v <= 1'b0;
        end
        if (prod_v) acc <= acc + acc_t'(prod);
      end

      case (step)
        P_IDLE: begin
          if (head.valid) begin
            dv[0] <= head.item.d.dir_x;
            dv[1] <= head.item.d.dir_y;
            dv[2] <= head.item.d.dir_z;
            for (int i = 0; i < 3; i++) f[i] <= '0;
            mac_t  <= 2'd0;
            prod_v <= 1'b0;
            acc    <= '0;
            step   <= head.item.zero ? P_PAR : P_SS;
          end
        end
        P_SS: begin
          if (mac_done) begin
            sq_in    <= {acc[31:0], 32'd0};
            sq_start <= 1'b1;
            step     <= P_SQ1;
          end
        end
        P_SQ1: begin
          if (sq_done) begin
            div_num   <= 64'(dv[0]) <<< 46;
            div_den   <= sq_root;
            div_start <= 1'b1;
            idx       <= 2'd0;
            step      <= P_F;
          end
        end
        P_F: begin
          if (div_done) begin
            f[idx] <= clamp_unit(div_q);
            if (idx == 2'd2) begin
              step <= P_PAR;
            end else begin
              idx       <= nidx;
              div_num   <= 64'(dv[nidx]) <<< 46;
              div_start <= 1'b1;
            end
          end
        end
        P_PAR: begin
          if (par) begin
            r[0] <= -f[2]; r[1] <= '0; r[2] <= f[0];
          end else begin
            r[0] <= f[1]; r[1] <= -f[0]; r[2] <= '0;
          end
          mac_t  <= 2'd0;
          prod_v <= 1'b0;
          acc    <= '0;
          step   <= P_RR;
        end
        P_RR: begin
          if (mac_done) begin
            sq_in    <= acc[63:0];
            sq_start <= 1'b1;
            step     <= P_SQ2;
          end
        end
        P_SQ2: begin
          if (sq_done) begin
            idx <= 2'd0;
            if (sq_root == 32'd0) begin
              mac_t  <= 2'd0;
              prod_v <= 1'b0;
              acc    <= '0;
              step   <= P_U;
            end else begin
              div_num   <= 64'(r[0]) <<< 30;
              div_den   <= sq_root;
              div_start <= 1'b1;
              step      <= P_R;
            end
          end
        end
        P_R: begin
          if (div_done) begin
            r[idx] <= clamp_unit(div_q);
            if (idx == 2'd2) begin
              idx    <= 2'd0;
              mac_t  <= 2'd0;
              prod_v <= 1'b0;
              acc    <= '0;
              step   <= P_U;
            end else begin
              idx       <= nidx;
              div_num   <= 64'(r[nidx]) <<< 30;
              div_start <= 1'b1;
            end
          end
        end
        P_U: begin
          if (mac_done) begin
            u[idx] <= op_t'(rnd_shift(acc, 30));
            mac_t  <= 2'd0;
            acc    <= '0;
            if (idx == 2'd2) step <= P_RF;
            else idx <= nidx;
          end
        end
        P_RF: begin
          if (mac_done) begin
            rf     <= acc;
            mac_t  <= 2'd0;
            acc    <= '0;
            step   <= P_UF;
          end
        end
        P_UF: begin
          if (mac_done) begin
            uf     <= acc;
            mac_t  <= 2'd0;
            acc    <= '0;
            step   <= P_FF;
          end
        end
        P_FF: begin
          if (mac_done) begin
            ffx <= acc_t'(200) * rnd_shift(acc, 30) - acc_t'(201) * acc_t'(ONE30);
            idx      <= 2'd0;
            jdx      <= 2'd0;
            div_num  <= 64'(r[0]);
            cd_sel   <= SEL_A;
            cd_start <= 1'b1;
            step     <= P_COL;
          end
        end
        P_COL: begin
          if (cd_done) begin
            rows[jdx] <= sat32(acc_t'(cd_q));
            if (jdx == 2'd2) begin
              rows[3] <= 32'sd0;
              step    <= P_EMIT;
            end else if (jdx == 2'd0) begin
              jdx      <= 2'd1;
              div_num  <= 64'(u[idx]);
              cd_start <= 1'b1;
            end else begin
              jdx      <= 2'd2;
              div_num  <= 64'(f[idx]) <<< 1;
              cd_sel   <= SEL_B;
              cd_start <= 1'b1;
            end
          end
        end
        P_NUM: begin
          if (cd_done) begin
            rows[2] <= sat32(acc_t'(cd_q));
            step    <= P_EMIT;
          end
        end
        P_EMIT: begin
          if (!out_full) begin
            if (idx == 2'd3) begin
              step <= P_IDLE;
            end else if (idx == 2'd2) begin
              idx      <= 2'd3;
              rows[0]  <= sat32(rnd_shift(rf, 60 - OUT_FRAC_BITS));
              rows[1]  <= sat32(rnd_shift(uf, 60 - OUT_FRAC_BITS));
              rows[3]  <= ONE_OUT;
              div_num  <= 64'(ffx);
              cd_sel   <= SEL_B;
              cd_start <= 1'b1;
              step     <= P_NUM;
            end else begin
              idx      <= nidx;
              jdx      <= 2'd0;
              div_num  <= 64'(r[nidx]);
              cd_sel   <= SEL_A;
              cd_start <= 1'b1;
              step     <= P_COL;
            end
          end
        end
        default: step <= P_IDLE;
      endcase
    end
  end

endmodule

[design/lsmb_outq.sv]
module lsmb_outq import lsmb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  bq_t  bq,
  output logic full,
  input  logic pop,
  output logic empty,
  output col_t res
);

  col_t       q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       do_pop;

  assign full   = cnt == 3'd4;
  assign empty  = cnt == 3'd0;
  assign do_pop = pop && !empty;
  assign res    = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (bq.push) begin
        q[wp] <= bq.col;
        wp    <= wp + 2'd1;
      end
      if (do_pop) rp <= rp + 2'd1;
      cnt <= cnt + 3'(bq.push) - 3'(do_pop);
    end
  end

endmodule

[design/light_space_matrix_builder.sv]
// Each accepted direction yields four column words; a new direction is taken only
// once the sequencer is idle again after the last word of the previous one. The
// shared bit-serial divider (six 64-step divisions), two 32-step roots and ten
// 8-step constant divisions per matrix set the rate at which directions are taken.
// A zero direction skips the first root and all six divisions.
// Two directions queue at the input and four column words at the output.
// Reset (rst, synchronous) empties both queues and idles the sequencer.
module light_space_matrix_builder import lsmb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  dir_t dir,
  output logic empty,
  input  logic pop,
  output col_t res
);

  fq_t  head;
  logic deq;
  logic out_full;
  bq_t  bq;

  lsmb_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .dir(dir), .head(head), .deq(deq)
  );

  lsmb_back u_back (
    .clk(clk), .rst(rst), .head(head), .deq(deq), .out_full(out_full), .bq(bq)
  );

  lsmb_outq u_outq (
    .clk(clk), .rst(rst), .bq(bq), .full(out_full), .pop(pop), .empty(empty), .res(res)
  );

endmodule

[design/lsmb_checker.sv]
module lsmb_checker import lsmb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input col_t res
);

  a_rst: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (res.last_column == (res.column_index == 2'd3)))
    else $error("last_column disagrees with column_index");

  a_row3_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.last_column) |-> (res.row3 == ONE_OUT))
    else $error("column 3 row 3 is not one");

  a_row3_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !res.last_column) |-> (res.row3 == 32'sd0))
    else $error("row 3 of columns 0..2 not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(res)))
    else $error("waiting word changed");

endmodule

bind light_space_matrix_builder lsmb_checker u_chk (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop), .res(res)
);

[verif/lsmb_checker.sv]
module lsmb_tb_checker import lsmb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  dir_t dir,
  input  logic empty,
  input  logic pop,
  input  col_t res,
  output int   pending,
  output int   errors
);

  localparam longint UNIT = 64'sd1 <<< 30;

  col_t columns_due[$];

  function automatic longint div_near(longint n, longint unsigned d);
    longint unsigned m;
    longint unsigned q;
    if (d == 0) return 0;
    m = (n < 0) ? longint'(-n) : longint'(n);
    q = (m + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned acc;
    longint unsigned b;
    acc = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= acc + b) begin
        x = x - (acc + b);
        acc = (acc >> 1) + b;
      end else begin
        acc = acc >> 1;
      end
      b = b >> 2;
    end
    return acc;
  endfunction

  function automatic longint to_unit(longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint dot3(longint a[3], longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // look-at basis in Q30, then the four column words of view * ortho
  function void queue_matrix(dir_t v);
    longint d[3], f[3], r[3], u[3];
    longint rf, uf, ff, num, af;
    longint unsigned sq, len, dv;
    col_t w;
    d[0] = longint'(v.dir_x);
    d[1] = longint'(v.dir_y);
    d[2] = longint'(v.dir_z);
    f = '{0, 0, 0};
    sq = longint'(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
    if (sq != 0) begin
      len = int_sqrt(sq << 32);
      for (int i = 0; i < 3; i++) f[i] = to_unit(div_near(d[i] * (64'sd1 <<< 46), len));
    end
    af = (f[2] < 0) ? -f[2] : f[2];
    // near-vertical light swaps up to +y
    if (100 * af > 99 * UNIT) r = '{-f[2], 0, f[0]};
    else r = '{f[1], -f[0], 0};
    len = int_sqrt(longint'(dot3(r, r)));
    if (len != 0)
      for (int i = 0; i < 3; i++) r[i] = to_unit(div_near(r[i] * UNIT, len));
    u[0] = div_near(r[1] * f[2] - r[2] * f[1], 64'd1 << 30);
    u[1] = div_near(r[2] * f[0] - r[0] * f[2], 64'd1 << 30);
    u[2] = div_near(r[0] * f[1] - r[1] * f[0], 64'd1 << 30);
    rf = dot3(r, f);
    uf = dot3(u, f);
    ff = dot3(f, f);
    for (int c = 0; c < 3; c++) begin
      w.column_index = 2'(c);
      dv = 64'd100 << (30 - OUT_FRAC_BITS);
      w.row0 = clip32(div_near(r[c], dv));
      w.row1 = clip32(div_near(u[c], dv));
      dv = 64'd199 << (30 - OUT_FRAC_BITS);
      w.row2 = clip32(div_near(2 * f[c], dv));
      w.row3 = '0;
      w.last_column = 1'b0;
      columns_due.push_back(w);
    end
    num = 200 * div_near(ff, 64'd1 << 30) - 201 * UNIT;
    w.column_index = 2'd3;
    w.row0 = clip32(div_near(rf, 64'd1 << (60 - OUT_FRAC_BITS)));
    w.row1 = clip32(div_near(uf, 64'd1 << (60 - OUT_FRAC_BITS)));
    w.row2 = clip32(div_near(num, 64'd199 << (30 - OUT_FRAC_BITS)));
    w.row3 = clip32(64'sd1 <<< OUT_FRAC_BITS);
    w.last_column = 1'b1;
    columns_due.push_back(w);
  endfunction

  assign pending = columns_due.size();

  initial errors = 0;

  always @(posedge clk) begin
    col_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (columns_due.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected word: %p", res);
        end else begin
          want = columns_due.pop_front();
          if (res.column_index !== want.column_index || res.row0 !== want.row0 ||
              res.row1 !== want.row1 || res.row2 !== want.row2 ||
              res.row3 !== want.row3 || res.last_column !== want.last_column) begin
            errors <= errors + 1;
            if (errors < 10) $display("mismatch: expected %p got %p", want, res);
          end
        end
      end
      if (push && !full) queue_matrix(dir);
    end
  end

endmodule

[verif/tb_light_space_matrix_builder.sv]
module tb_light_space_matrix_builder;
  import lsmb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  dir_t dir = '0;
  col_t res;
  int   pending, errors;
  bit   hold_out = 1'b0;
  bit   fast_pop = 1'b0;
  int   quiet = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  light_space_matrix_builder u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .dir(dir),
    .empty(empty), .pop(pop), .res(res)
  );

  lsmb_tb_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .dir(dir),
    .empty(empty), .pop(pop), .res(res), .pending(pending), .errors(errors)
  );

  // no word moved for this long means the block is hung
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(dir_t v, int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    dir <= v;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic dir_t rand_dir();
    dir_t v;
    case ($urandom_range(0, 3))
      0: v = dir_t'(48'({$urandom, $urandom}));
      1: begin
        v.dir_x = 16'($signed($urandom_range(0, 40)) - 20);
        v.dir_y = 16'($signed($urandom_range(0, 40)) - 20);
        v.dir_z = 16'($signed($urandom_range(0, 40)) - 20);
      end
      // close to the vertical, around the up-vector switch
      2: begin
        v.dir_x = 16'($signed($urandom_range(0, 400)) - 200);
        v.dir_y = 16'($signed($urandom_range(0, 400)) - 200);
        v.dir_z = $urandom_range(0, 1) ? 16'sd1400 : -16'sd1400;
      end
      default: begin
        v = dir_t'(48'({$urandom, $urandom}));
        v.dir_z = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
    endcase
    return v;
  endfunction

  // receiver
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_out) begin
        pop <= 1'b0;
        repeat (4000) @(posedge clk);
        hold_out = 1'b0;
      end
      stall = fast_pop ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  initial begin
    dir_t plan[$];
    plan = '{
      dir_t'({16'sd0, 16'sd0, 16'sd0}), dir_t'({16'sd1, 16'sd0, 16'sd0}),
      dir_t'({16'sd0, 16'sd1, 16'sd0}), dir_t'({16'sd0, 16'sd0, 16'sd1}),
      dir_t'({16'sd0, 16'sd0, -16'sd5}), dir_t'({16'sh7fff, 16'sh7fff, 16'sh7fff}),
      dir_t'({16'sh8000, 16'sh8000, 16'sh8000}), dir_t'({16'sh7fff, 16'sh8000, 16'sd0}),
      dir_t'({16'sh8000, 16'sd0, 16'sh7fff}), dir_t'({16'sd0, 16'sh8000, 16'sh8000}),
      dir_t'({16'sd14, 16'sd0, 16'sd99}), dir_t'({16'sd0, 16'sd14, -16'sd99}),
      dir_t'({16'sd141, 16'sd0, 16'sd1000}), dir_t'({16'sd1, 16'sd1, 16'sd0}),
      dir_t'({-16'sd1, 16'sd0, 16'sd100}), dir_t'({16'sd3, -16'sd4, 16'sd12}),
      dir_t'({16'shffff, 16'shffff, 16'shffff}), dir_t'({16'sh5555, 16'shaaaa, 16'sh0f0f})
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i]) send(plan[i], $urandom_range(0, 10));

    // back-pressure: output held while directions keep coming
    hold_out = 1'b1;
    repeat (8) send(rand_dir(), 0);

    for (int n = 0; n < 134; n++) begin
      if (n == 60) begin
        push <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
      if (n % 40 == 20) fast_pop = ~fast_pop;
      send(rand_dir(), (n % 50 < 10) ? 0 : $urandom_range(0, 10));
    end
    push <= 1'b0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
